FILE: design/kf3_pkg.sv
// ----------------------------------------------------------------------------
// kf3_pkg
// Shared types, register-file map and micro-program for the three-state
// altitude Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kf3_pkg;

  // Operations of the shared arithmetic unit
  typedef enum logic [3:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_SAT48,
    OP_MUL,
    OP_RECIP,
    OP_OUTA,
    OP_OUTV,
    OP_END
  } op_t;

  // Product scaling: F, F+1, 32 or 16 fraction bits dropped
  typedef enum logic [1:0] {
    SH_F,
    SH_F1,
    SH_32,
    SH_16
  } sh_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] sa;
    logic [6:0] sb;
    logic [5:0] dst;
    sh_t        sh;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_NEG,
    AS_RND,
    AS_DIV,
    AS_FIN
  } alu_state_t;

  // Sequencer strobes towards the datapath
  typedef struct packed {
    logic rd;
    logic start;
    logic wr;
    logic out_alt;
    logic out_vel;
    logic push;
    logic clr_sat;
    logic boot;
  } ctrl_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_MEAS_VAR  = 3'd0;
  localparam logic [2:0] CFG_ACCEL_VAR = 3'd1;
  localparam logic [2:0] CFG_BIAS_VAR  = 3'd2;
  localparam logic [2:0] CFG_INIT_ALT  = 3'd3;
  localparam logic [2:0] CFG_INIT_VEL  = 3'd4;
  localparam logic [2:0] CFG_INIT_BIAS = 3'd5;

  // Register file slots (operand codes with the top bit clear)
  localparam logic [6:0] RP0 = 7'd0;
  localparam logic [6:0] RP1 = 7'd1;
  localparam logic [6:0] RP2 = 7'd2;
  localparam logic [6:0] RP3 = 7'd3;
  localparam logic [6:0] RP4 = 7'd4;
  localparam logic [6:0] RP5 = 7'd5;
  localparam logic [6:0] RP6 = 7'd6;
  localparam logic [6:0] RP7 = 7'd7;
  localparam logic [6:0] RP8 = 7'd8;
  localparam logic [6:0] RT0 = 7'd9;
  localparam logic [6:0] RT1 = 7'd10;
  localparam logic [6:0] RT2 = 7'd11;
  localparam logic [6:0] RT3 = 7'd12;
  localparam logic [6:0] RT4 = 7'd13;
  localparam logic [6:0] RT5 = 7'd14;
  localparam logic [6:0] RT6 = 7'd15;
  localparam logic [6:0] RT7 = 7'd16;
  localparam logic [6:0] RT8 = 7'd17;
  localparam logic [6:0] RALT = 7'd18;
  localparam logic [6:0] RVEL = 7'd19;
  localparam logic [6:0] RBIAS = 7'd20;
  localparam logic [6:0] RAT = 7'd21;
  localparam logic [6:0] RD2 = 7'd22;
  localparam logic [6:0] RD3 = 7'd23;
  localparam logic [6:0] RD4 = 7'd24;
  localparam logic [6:0] RDD = 7'd25;
  localparam logic [6:0] RK0 = 7'd26;
  localparam logic [6:0] RK1 = 7'd27;
  localparam logic [6:0] RK2 = 7'd28;
  localparam logic [6:0] RR0 = 7'd29;
  localparam logic [6:0] RR1 = 7'd30;
  localparam logic [6:0] RR2 = 7'd31;
  localparam logic [6:0] RS = 7'd32;
  localparam logic [6:0] RSINV = 7'd33;
  localparam logic [6:0] RINNOV = 7'd34;
  localparam logic [6:0] RX = 7'd35;
  localparam logic [6:0] RY = 7'd36;

  // Special operand sources
  localparam logic [3:0] SC_ZERO  = 4'd0;
  localparam logic [3:0] SC_ONE   = 4'd1;
  localparam logic [3:0] SC_DT16  = 4'd2;
  localparam logic [3:0] SC_DT    = 4'd3;
  localparam logic [3:0] SC_ALT   = 4'd4;
  localparam logic [3:0] SC_ACC   = 4'd5;
  localparam logic [3:0] SC_QA    = 4'd6;
  localparam logic [3:0] SC_QB    = 4'd7;
  localparam logic [3:0] SC_MR    = 4'd8;
  localparam logic [3:0] SC_IALT  = 4'd9;
  localparam logic [3:0] SC_IVEL  = 4'd10;
  localparam logic [3:0] SC_IBIAS = 4'd11;
  localparam logic [3:0] SC_P22   = 4'd12;

  localparam logic [6:0] S_ZERO  = {3'b100, SC_ZERO};
  localparam logic [6:0] S_ONE   = {3'b100, SC_ONE};
  localparam logic [6:0] S_DT16  = {3'b100, SC_DT16};
  localparam logic [6:0] S_DT    = {3'b100, SC_DT};
  localparam logic [6:0] S_ALT   = {3'b100, SC_ALT};
  localparam logic [6:0] S_ACC   = {3'b100, SC_ACC};
  localparam logic [6:0] S_QA    = {3'b100, SC_QA};
  localparam logic [6:0] S_QB    = {3'b100, SC_QB};
  localparam logic [6:0] S_MR    = {3'b100, SC_MR};
  localparam logic [6:0] S_IALT  = {3'b100, SC_IALT};
  localparam logic [6:0] S_IVEL  = {3'b100, SC_IVEL};
  localparam logic [6:0] S_IBIAS = {3'b100, SC_IBIAS};
  localparam logic [6:0] S_P22   = {3'b100, SC_P22};

  // Program entry points
  localparam logic [6:0] PC_MEAS = 7'd0;
  localparam logic [6:0] PC_RST  = 7'd104;

  function automatic uop_t mk(op_t op, logic [6:0] sa, logic [6:0] sb,
                              logic [6:0] d, sh_t sh);
    uop_t r;
    r.op  = op;
    r.sa  = sa;
    r.sb  = sb;
    r.dst = d[5:0];
    r.sh  = sh;
    return r;
  endfunction

  function automatic uop_t mov(logic [6:0] d, logic [6:0] a);
    return mk(OP_MOV, a, S_ZERO, d, SH_F);
  endfunction

  function automatic uop_t add(logic [6:0] d, logic [6:0] a, logic [6:0] b);
    return mk(OP_ADD, a, b, d, SH_F);
  endfunction

  function automatic uop_t sub(logic [6:0] d, logic [6:0] a, logic [6:0] b);
    return mk(OP_SUB, a, b, d, SH_F);
  endfunction

  function automatic uop_t s48(logic [6:0] d, logic [6:0] a);
    return mk(OP_SAT48, a, S_ZERO, d, SH_F);
  endfunction

  function automatic uop_t mul(logic [6:0] d, logic [6:0] a, logic [6:0] b, sh_t sh);
    return mk(OP_MUL, a, b, d, sh);
  endfunction

  function automatic logic writes_reg(op_t op);
    return (op == OP_MOV) || (op == OP_ADD) || (op == OP_SUB) ||
           (op == OP_SAT48) || (op == OP_MUL) || (op == OP_RECIP);
  endfunction

  // Micro-program: measurement update from PC_MEAS, restart from PC_RST
  function automatic uop_t prog(logic [6:0] pc);
    uop_t r;
    case (pc)
      // state prediction
      7'd0:   r = sub(RX, S_ACC, RBIAS);
      7'd1:   r = s48(RAT, RX);
      7'd2:   r = mul(RX, RAT, S_DT16, SH_16);
      7'd3:   r = add(RX, RVEL, RX);
      7'd4:   r = s48(RVEL, RX);
      7'd5:   r = mul(RX, RVEL, S_DT16, SH_16);
      7'd6:   r = add(RX, RALT, RX);
      7'd7:   r = s48(RALT, RX);
      // time powers
      7'd8:   r = mul(RD2, S_DT, S_DT, SH_F1);
      7'd9:   r = mul(RD3, RD2, S_DT, SH_F);
      7'd10:  r = mul(RD4, RD2, RD2, SH_F);
      7'd11:  r = mul(RDD, S_DT, S_DT, SH_F);
      // T = A * P, column 0
      7'd12:  r = mul(RX, S_DT, RP3, SH_F);
      7'd13:  r = add(RX, RP0, RX);
      7'd14:  r = mul(RY, RD2, RP6, SH_F);
      7'd15:  r = sub(RT0, RX, RY);
      7'd16:  r = mul(RX, S_DT, RP6, SH_F);
      7'd17:  r = sub(RT3, RP3, RX);
      7'd18:  r = mov(RT6, RP6);
      // column 1
      7'd19:  r = mul(RX, S_DT, RP4, SH_F);
      7'd20:  r = add(RX, RP1, RX);
      7'd21:  r = mul(RY, RD2, RP7, SH_F);
      7'd22:  r = sub(RT1, RX, RY);
      7'd23:  r = mul(RX, S_DT, RP7, SH_F);
      7'd24:  r = sub(RT4, RP4, RX);
      7'd25:  r = mov(RT7, RP7);
      // column 2
      7'd26:  r = mul(RX, S_DT, RP5, SH_F);
      7'd27:  r = add(RX, RP2, RX);
      7'd28:  r = mul(RY, RD2, RP8, SH_F);
      7'd29:  r = sub(RT2, RX, RY);
      7'd30:  r = mul(RX, S_DT, RP8, SH_F);
      7'd31:  r = sub(RT5, RP5, RX);
      7'd32:  r = mov(RT8, RP8);
      // P = T * A', row 0
      7'd33:  r = mul(RX, S_DT, RT1, SH_F);
      7'd34:  r = add(RX, RT0, RX);
      7'd35:  r = mul(RY, RD2, RT2, SH_F);
      7'd36:  r = sub(RP0, RX, RY);
      7'd37:  r = mul(RX, S_DT, RT2, SH_F);
      7'd38:  r = sub(RP1, RT1, RX);
      7'd39:  r = mov(RP2, RT2);
      // row 1
      7'd40:  r = mul(RX, S_DT, RT4, SH_F);
      7'd41:  r = add(RX, RT3, RX);
      7'd42:  r = mul(RY, RD2, RT5, SH_F);
      7'd43:  r = sub(RP3, RX, RY);
      7'd44:  r = mul(RX, S_DT, RT5, SH_F);
      7'd45:  r = sub(RP4, RT4, RX);
      7'd46:  r = mov(RP5, RT5);
      // row 2
      7'd47:  r = mul(RX, S_DT, RT7, SH_F);
      7'd48:  r = add(RX, RT6, RX);
      7'd49:  r = mul(RY, RD2, RT8, SH_F);
      7'd50:  r = sub(RP6, RX, RY);
      7'd51:  r = mul(RX, S_DT, RT8, SH_F);
      7'd52:  r = sub(RP7, RT7, RX);
      7'd53:  r = mov(RP8, RT8);
      // process noise
      7'd54:  r = mul(RX, RD4, S_QA, SH_32);
      7'd55:  r = add(RP0, RP0, RX);
      7'd56:  r = mul(RX, RD3, S_QA, SH_32);
      7'd57:  r = add(RP1, RP1, RX);
      7'd58:  r = add(RP3, RP3, RX);
      7'd59:  r = mul(RX, RDD, S_QA, SH_32);
      7'd60:  r = add(RP4, RP4, RX);
      7'd61:  r = mul(RX, S_QB, S_ONE, SH_32);
      7'd62:  r = add(RP8, RP8, RX);
      // innovation and gains
      7'd63:  r = sub(RX, S_ALT, RALT);
      7'd64:  r = s48(RINNOV, RX);
      7'd65:  r = mul(RX, S_MR, S_ONE, SH_32);
      7'd66:  r = add(RS, RP0, RX);
      7'd67:  r = mk(OP_RECIP, RS, S_ZERO, RSINV, SH_F);
      7'd68:  r = mul(RK0, RP0, RSINV, SH_F);
      7'd69:  r = mul(RK1, RP3, RSINV, SH_F);
      7'd70:  r = mul(RK2, RP6, RSINV, SH_F);
      // state correction
      7'd71:  r = mul(RX, RK0, RINNOV, SH_F);
      7'd72:  r = add(RX, RALT, RX);
      7'd73:  r = s48(RALT, RX);
      7'd74:  r = mul(RX, RK1, RINNOV, SH_F);
      7'd75:  r = add(RX, RVEL, RX);
      7'd76:  r = s48(RVEL, RX);
      7'd77:  r = mul(RX, RK2, RINNOV, SH_F);
      7'd78:  r = add(RX, RBIAS, RX);
      7'd79:  r = s48(RBIAS, RX);
      // covariance correction from the pre-update first row
      7'd80:  r = mov(RR0, RP0);
      7'd81:  r = mov(RR1, RP1);
      7'd82:  r = mov(RR2, RP2);
      7'd83:  r = mul(RX, RK0, RR0, SH_F);
      7'd84:  r = sub(RP0, RP0, RX);
      7'd85:  r = mul(RX, RK0, RR1, SH_F);
      7'd86:  r = sub(RP1, RP1, RX);
      7'd87:  r = mul(RX, RK0, RR2, SH_F);
      7'd88:  r = sub(RP2, RP2, RX);
      7'd89:  r = mul(RX, RK1, RR0, SH_F);
      7'd90:  r = sub(RP3, RP3, RX);
      7'd91:  r = mul(RX, RK1, RR1, SH_F);
      7'd92:  r = sub(RP4, RP4, RX);
      7'd93:  r = mul(RX, RK1, RR2, SH_F);
      7'd94:  r = sub(RP5, RP5, RX);
      7'd95:  r = mul(RX, RK2, RR0, SH_F);
      7'd96:  r = sub(RP6, RP6, RX);
      7'd97:  r = mul(RX, RK2, RR1, SH_F);
      7'd98:  r = sub(RP7, RP7, RX);
      7'd99:  r = mul(RX, RK2, RR2, SH_F);
      7'd100: r = sub(RP8, RP8, RX);
      7'd101: r = mk(OP_OUTA, RALT, S_ZERO, RX, SH_F);
      7'd102: r = mk(OP_OUTV, RVEL, S_ZERO, RX, SH_F);
      7'd103: r = mk(OP_END, S_ZERO, S_ZERO, RX, SH_F);
      // restart
      7'd104: r = mov(RALT, S_IALT);
      7'd105: r = mov(RVEL, S_IVEL);
      7'd106: r = mov(RBIAS, S_IBIAS);
      7'd107: r = mov(RP0, S_ONE);
      7'd108: r = mov(RP1, S_ZERO);
      7'd109: r = mov(RP2, S_ZERO);
      7'd110: r = mov(RP3, S_ZERO);
      7'd111: r = mov(RP4, S_ONE);
      7'd112: r = mov(RP5, S_ZERO);
      7'd113: r = mov(RP6, S_ZERO);
      7'd114: r = mov(RP7, S_ZERO);
      7'd115: r = mov(RP8, S_P22);
      7'd116: r = mk(OP_OUTA, RALT, S_ZERO, RX, SH_F);
      7'd117: r = mk(OP_OUTV, RVEL, S_ZERO, RX, SH_F);
      default: r = mk(OP_END, S_ZERO, S_ZERO, RX, SH_F);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/kf3_alu.sv
// ----------------------------------------------------------------------------
// kf3_alu
// Shared arithmetic unit: saturating add/sub/clip, 64x64 rounded product
// built from four 32x32 partials, and a restoring reciprocal divider.
// ----------------------------------------------------------------------------
`default_nettype none

module kf3_alu import kf3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire op_t         op,
  input  wire sh_t         sh,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      res,
  output logic             sat
);

  localparam int unsigned DIV_TOP = 2 * FRAC_BITS;
  localparam int unsigned IW      = $clog2(DIV_TOP + 1);
  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};

  alu_state_t      state;
  alu_state_t      state_next;
  logic [63:0]     ua;
  logic [63:0]     ub;
  logic            neg;
  logic [1:0]      step;
  logic [127:0]    acc;
  logic [6:0]      shamt;
  logic [63:0]     rem;
  logic [63:0]     quo;
  logic            ov;
  logic [IW-1:0]   idx;
  logic [63:0]     dvs;

  logic [64:0]     sum65;
  logic [64:0]     dif65;
  logic            fit48;
  logic            fit32;
  logic [31:0]     opa_w;
  logic [31:0]     opb_w;
  logic [63:0]     pp;
  logic [1:0]      pp_pos;
  logic [127:0]    rnd;
  logic [127:0]    quot;
  logic            fits;
  logic [63:0]     r2;
  logic            ge;
  logic [63:0]     rem_n;
  logic [63:0]     quo_n;
  logic            ov_n;
  logic            nonpos;

  // Saturating sums and range checks
  assign sum65 = {a[63], a} + {b[63], b};
  assign dif65 = {a[63], a} - {b[63], b};
  assign fit48 = (&a[63:47]) | ~(|a[63:47]);
  assign fit32 = (&a[63:31]) | ~(|a[63:31]);
  assign nonpos = a[63] | ~(|a);

  // One 32x32 partial product per cycle
  assign opa_w  = step[1] ? ua[63:32] : ua[31:0];
  assign opb_w  = step[0] ? ub[63:32] : ub[31:0];
  assign pp     = 64'(opa_w) * 64'(opb_w);
  assign pp_pos = {1'b0, step[1]} + {1'b0, step[0]};

  // Round half up, arithmetic shift and range check
  assign rnd  = acc + (128'd1 << (shamt - 7'd1));
  assign quot = 128'($signed(rnd) >>> shamt);
  assign fits = (&quot[127:63]) | ~(|quot[127:63]);

  // Restoring division step
  assign r2    = {rem[62:0], (idx == DIV_TOP[IW-1:0])};
  assign ge    = r2 >= dvs;
  assign rem_n = ge ? (r2 - dvs) : r2;
  assign quo_n = {quo[62:0], ge};
  assign ov_n  = ov | quo[63] | quo[62];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      AS_IDLE: begin
        if (start) begin
          case (op)
            OP_MUL:   state_next = AS_MUL;
            OP_RECIP: state_next = nonpos ? AS_FIN : AS_DIV;
            default:  state_next = AS_FIN;
          endcase
        end
      end
      AS_MUL:  if (step == 2'd3) state_next = AS_NEG;
      AS_NEG:  state_next = AS_RND;
      AS_RND:  state_next = AS_FIN;
      AS_DIV:  if (idx == '0) state_next = AS_FIN;
      AS_FIN:  state_next = AS_IDLE;
      default: state_next = AS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == AS_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      AS_IDLE: begin
        if (start) begin
          ua    <= a[63] ? (64'd0 - a) : a;
          ub    <= b[63] ? (64'd0 - b) : b;
          neg   <= a[63] ^ b[63];
          step  <= 2'd0;
          acc   <= '0;
          dvs   <= a;
          rem   <= '0;
          quo   <= '0;
          ov    <= 1'b0;
          idx   <= DIV_TOP[IW-1:0];
          case (sh)
            SH_F:    shamt <= 7'(FRAC_BITS);
            SH_F1:   shamt <= 7'(FRAC_BITS + 1);
            SH_32:   shamt <= 7'd32;
            SH_16:   shamt <= 7'd16;
            default: shamt <= 7'd32;
          endcase
          case (op)
            OP_ADD: begin
              res <= (sum65[64] != sum65[63]) ? {sum65[64], {63{~sum65[64]}}}
                                               : sum65[63:0];
              sat <= sum65[64] != sum65[63];
            end
            OP_SUB: begin
              res <= (dif65[64] != dif65[63]) ? {dif65[64], {63{~dif65[64]}}}
                                               : dif65[63:0];
              sat <= dif65[64] != dif65[63];
            end
            OP_SAT48: begin
              res <= fit48 ? a : {{17{a[63]}}, {47{~a[63]}}};
              sat <= ~fit48;
            end
            OP_OUTA, OP_OUTV: begin
              res <= fit32 ? a : {{33{a[63]}}, {31{~a[63]}}};
              sat <= ~fit32;
            end
            OP_RECIP: begin
              // non-positive innovation variance gives zero gains
              res <= '0;
              sat <= 1'b1;
            end
            default: begin
              res <= a;
              sat <= 1'b0;
            end
          endcase
        end
      end
      AS_MUL: begin
        acc  <= acc + ({64'd0, pp} << {pp_pos, 5'd0});
        step <= step + 2'd1;
      end
      AS_NEG: begin
        if (neg) acc <= 128'd0 - acc;
      end
      AS_RND: begin
        res <= fits ? quot[63:0] : {quot[127], {63{~quot[127]}}};
        sat <= ~fits;
      end
      AS_DIV: begin
        rem <= rem_n;
        quo <= quo_n;
        ov  <= ov_n;
        idx <= idx - 1'b1;
        if (idx == '0) begin
          res <= (ov_n | quo_n[63]) ? S64_MAX : quo_n;
          sat <= ov_n | quo_n[63];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/kf3_ctrl.sv
// ----------------------------------------------------------------------------
// kf3_ctrl
// Micro-program sequencer: fetches one operation, runs it on the shared
// unit, writes back, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kf3_ctrl import kf3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_cmd,
  input  wire logic alu_done,
  input  wire logic out_busy,
  output logic      in_ready,
  output ctrl_t     ctl,
  output uop_t      uop
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic [6:0]  pc;
  logic        boot;

  assign uop = prog(pc);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_FETCH;
      ST_FETCH: state_next = (uop.op == OP_END) ? ST_DONE : ST_EXEC;
      ST_EXEC:  state_next = ST_WAIT;
      ST_WAIT:  if (alu_done) state_next = ST_FETCH;
      ST_DONE:  if (boot || !out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = (state == ST_IDLE);
    ctl.rd      = (state == ST_FETCH);
    ctl.start   = (state == ST_EXEC);
    ctl.wr      = (state == ST_WAIT) && alu_done && writes_reg(uop.op);
    ctl.out_alt = (state == ST_WAIT) && alu_done && (uop.op == OP_OUTA);
    ctl.out_vel = (state == ST_WAIT) && alu_done && (uop.op == OP_OUTV);
    ctl.push    = (state == ST_DONE) && !boot && !out_busy;
    ctl.clr_sat = (state == ST_IDLE) && in_valid;
    ctl.boot    = boot;
  end

  // Reset runs the restart program once, with the initial values forced to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FETCH;
      pc    <= PC_RST;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) pc <= in_cmd ? PC_RST : PC_MEAS;
      if (state == ST_WAIT && alu_done) pc <= pc + 7'd1;
      if (state == ST_DONE) boot <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/altitude_kalman_filter_3state.sv
// ----------------------------------------------------------------------------
// altitude_kalman_filter_3state
// Three-state altitude/velocity/bias Kalman filter on one shared arithmetic
// unit driven by a micro-program over a 64-entry register file.
// Operation: a measurement runs 103 operations, one at a time, on the shared
//   unit; a restart runs the restart program.
// Throughput: one item per run; the sequencer takes a new item only when
//   idle, after the last result has gone to the output register.
// Reset: synchronous; after reset the restart program runs once (no input
//   taken) to load zero states and the initial covariance.
// ----------------------------------------------------------------------------
`default_nettype none

module altitude_kalman_filter_3state import kf3_pkg::*; #(
  parameter int unsigned STATE_FRAC_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command, altitude_sample, accel_sample, time_step (from bit 0 up)
  input  wire logic [87:0] s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // altitude_out, velocity_out, saturated (from bit 0 up)
  output logic [71:0]      m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  localparam logic [63:0] ONE_Q = 64'd1 << STATE_FRAC_BITS;
  localparam logic [63:0] P22_Q = 64'd100000 << STATE_FRAC_BITS;

  ctrl_t        ctl;
  uop_t         uop;
  logic         alu_done;
  logic [63:0]  alu_res;
  logic         alu_sat;

  logic [47:0]  meas_noise_var;
  logic [47:0]  accel_noise_var;
  logic [47:0]  bias_noise_var;
  logic [31:0]  initial_altitude;
  logic [31:0]  initial_velocity;
  logic [31:0]  initial_bias;

  logic [31:0]  alt_in;
  logic [31:0]  acc_in;
  logic [15:0]  dt_in;

  logic [63:0]  rf [64];
  logic [63:0]  opa;
  logic [63:0]  opb;
  logic [31:0]  alt_hold;
  logic [31:0]  vel_hold;
  logic         sat_acc;
  logic         in_xfer;

  function automatic logic [63:0] spec(input logic [3:0] c);
    logic [63:0] v;
    case (c)
      SC_ZERO:  v = '0;
      SC_ONE:   v = ONE_Q;
      SC_DT16:  v = {48'd0, dt_in};
      SC_DT:    v = {48'd0, dt_in} << (STATE_FRAC_BITS - 16);
      SC_ALT:   v = {{32{alt_in[31]}}, alt_in};
      SC_ACC:   v = {{32{acc_in[31]}}, acc_in};
      SC_QA:    v = {16'd0, accel_noise_var};
      SC_QB:    v = {16'd0, bias_noise_var};
      SC_MR:    v = {16'd0, meas_noise_var};
      SC_IALT:  v = ctl.boot ? '0 : {{32{initial_altitude[31]}}, initial_altitude};
      SC_IVEL:  v = ctl.boot ? '0 : {{32{initial_velocity[31]}}, initial_velocity};
      SC_IBIAS: v = ctl.boot ? '0 : {{32{initial_bias[31]}}, initial_bias};
      SC_P22:   v = P22_Q;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign in_xfer = s_tvalid && s_tready;

  kf3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tdata[0]),
    .alu_done (alu_done),
    .out_busy (m_tvalid && !m_tready),
    .in_ready (s_tready),
    .ctl      (ctl),
    .uop      (uop)
  );

  kf3_alu #(
    .FRAC_BITS (STATE_FRAC_BITS)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.start),
    .op    (uop.op),
    .sh    (uop.sh),
    .a     (opa),
    .b     (opb),
    .done  (alu_done),
    .res   (alu_res),
    .sat   (alu_sat)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_noise_var   <= 48'h0001_0000_0000;
      accel_noise_var  <= 48'h0001_0000_0000;
      bias_noise_var   <= '0;
      initial_altitude <= '0;
      initial_velocity <= '0;
      initial_bias     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MEAS_VAR:  meas_noise_var   <= cfg_data;
        CFG_ACCEL_VAR: accel_noise_var  <= cfg_data;
        CFG_BIAS_VAR:  bias_noise_var   <= cfg_data;
        CFG_INIT_ALT:  initial_altitude <= cfg_data[31:0];
        CFG_INIT_VEL:  initial_velocity <= cfg_data[31:0];
        CFG_INIT_BIAS: initial_bias     <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Input item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      alt_in <= s_tdata[32:1];
      acc_in <= s_tdata[64:33];
      dt_in  <= s_tdata[80:65];
    end
  end

  // Register file: one write port, operands read and registered
  always_ff @(posedge clk) begin
    if (ctl.wr) rf[uop.dst] <= alu_res;
    if (ctl.rd) begin
      opa <= uop.sa[6] ? spec(uop.sa[3:0]) : rf[uop.sa[5:0]];
      opb <= uop.sb[6] ? spec(uop.sb[3:0]) : rf[uop.sb[5:0]];
    end
  end

  // Clip flag and output hold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_acc <= 1'b0;
    end else if (ctl.clr_sat) begin
      sat_acc <= 1'b0;
    end else if (alu_done) begin
      sat_acc <= sat_acc | alu_sat;
    end
    if (ctl.out_alt) alt_hold <= alu_res[31:0];
    if (ctl.out_vel) vel_hold <= alu_res[31:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (ctl.push) m_tdata <= {7'd0, sat_acc, vel_hold, alt_hold};
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-state altitude Kalman filter. Commands go
// in through the stream input and results are checked against an in-bench
// fixed-point filter. The run covers four handshake pressure phases, with
// register settings changed between phases, including the extremes.
// ----------------------------------------------------------------------------
module tb;
  import kf3_pkg::*;

  localparam logic CMD_MEAS    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;
  localparam logic [2:0] CFG_NONE = 3'd6;   // unmapped index, must be ignored
  localparam int   WD_LIMIT    = 20000;
  localparam longint MAXL  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MINL  = -MAXL - 1;
  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint ONE   = 64'sd1 <<< 32;

  // fields from the highest bit down
  typedef struct packed {
    logic [15:0] dt;
    logic [31:0] acc;
    logic [31:0] alt;
    logic        cmd;
  } kf_in_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] vel;
    logic [31:0] alt;
  } kf_out_t;

  logic        clk;
  logic        rst;
  logic [87:0] s_tdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  altitude_kalman_filter_3state u_top (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kf_in_t  cmd_q[$];
  kf_out_t est_q[$];
  int      send_idle_pct, recv_stall_pct;
  int      errors, n_meas, n_restart, n_checked, n_sat, wd;
  logic    in_done;

  // filter copy kept by the bench
  logic [47:0] reg_copy[6];
  longint      alt_e, vel_e, bias_e;
  longint      cov[9];
  logic        clip;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- saturating arithmetic ----------------
  function automatic longint fit64(logic signed [127:0] r);
    if (r > MAXL) begin
      clip = 1'b1;
      return MAXL;
    end
    if (r < MINL) begin
      clip = 1'b1;
      return MINL;
    end
    return longint'(r);
  endfunction

  function automatic longint sadd(longint a, longint b);
    logic signed [127:0] r;
    r = a;
    r = r + b;
    return fit64(r);
  endfunction

  function automatic longint ssub(longint a, longint b);
    logic signed [127:0] r;
    r = a;
    r = r - b;
    return fit64(r);
  endfunction

  function automatic longint clip48(longint a);
    if (a > MAX48) begin
      clip = 1'b1;
      return MAX48;
    end
    if (a < MIN48) begin
      clip = 1'b1;
      return MIN48;
    end
    return a;
  endfunction

  // product shifted down by sh with round half up
  function automatic longint qmul(longint a, longint b, int sh);
    logic signed [127:0] p, ha, hb;
    ha = a;
    hb = b;
    p = ha * hb;
    p = p + (128'sd1 <<< (sh - 1));
    p = p >>> sh;
    return fit64(p);
  endfunction

  function automatic longint qrecip(longint d);
    logic [127:0] q;
    q = (128'd1 << 64) / {64'd0, d};
    if (q > 128'h7FFF_FFFF_FFFF_FFFF) begin
      clip = 1'b1;
      return MAXL;
    end
    return longint'(q);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void reload_filter();
    alt_e  = longint'(signed'(reg_copy[CFG_INIT_ALT][31:0]));
    vel_e  = longint'(signed'(reg_copy[CFG_INIT_VEL][31:0]));
    bias_e = longint'(signed'(reg_copy[CFG_INIT_BIAS][31:0]));
    foreach (cov[i]) cov[i] = 0;
    cov[0] = ONE;
    cov[4] = ONE;
    cov[8] = longint'(100000) <<< 32;
  endfunction

  // one filter step: restart or predict + altitude update
  function automatic kf_out_t kf_update(kf_in_t it);
    kf_out_t r;
    longint  a, dt, d2, d3, d4, dd, qa, s, sinv, innov;
    longint  t[9];
    longint  row0[3];
    longint  k[3];
    clip = 1'b0;
    if (it.cmd == CMD_RESTART) begin
      reload_filter();
      r.alt = sat32(alt_e);
      r.vel = sat32(vel_e);
      r.sat = 1'b0;
      return r;
    end
    a = clip48(ssub(longint'(signed'(it.acc)), bias_e));
    vel_e = clip48(sadd(vel_e, qmul(a, longint'(it.dt), 16)));
    alt_e = clip48(sadd(alt_e, qmul(vel_e, longint'(it.dt), 16)));
    dt = longint'(it.dt) <<< 16;
    d2 = qmul(dt, dt, 33);
    d3 = qmul(d2, dt, 32);
    d4 = qmul(d2, d2, 32);
    dd = qmul(dt, dt, 32);
    for (int j = 0; j < 3; j++) begin
      t[j] = ssub(sadd(cov[j], qmul(dt, cov[3+j], 32)), qmul(d2, cov[6+j], 32));
      t[3+j] = ssub(cov[3+j], qmul(dt, cov[6+j], 32));
      t[6+j] = cov[6+j];
    end
    for (int i = 0; i < 3; i++) begin
      cov[3*i] = ssub(sadd(t[3*i], qmul(dt, t[3*i+1], 32)), qmul(d2, t[3*i+2], 32));
      cov[3*i+1] = ssub(t[3*i+1], qmul(dt, t[3*i+2], 32));
      cov[3*i+2] = t[3*i+2];
    end
    // process noise
    qa = longint'({16'd0, reg_copy[CFG_ACCEL_VAR]});
    cov[0] = sadd(cov[0], qmul(d4, qa, 32));
    cov[1] = sadd(cov[1], qmul(d3, qa, 32));
    cov[3] = sadd(cov[3], qmul(d3, qa, 32));
    cov[4] = sadd(cov[4], qmul(dd, qa, 32));
    cov[8] = sadd(cov[8], qmul(longint'({16'd0, reg_copy[CFG_BIAS_VAR]}), ONE, 32));
    // gains; a non-positive innovation variance drops the measurement
    innov = clip48(ssub(longint'(signed'(it.alt)), alt_e));
    s = sadd(cov[0], qmul(longint'({16'd0, reg_copy[CFG_MEAS_VAR]}), ONE, 32));
    if (s <= 0) begin
      clip = 1'b1;
      k[0] = 0;
      k[1] = 0;
      k[2] = 0;
    end else begin
      sinv = qrecip(s);
      k[0] = qmul(cov[0], sinv, 32);
      k[1] = qmul(cov[3], sinv, 32);
      k[2] = qmul(cov[6], sinv, 32);
    end
    alt_e  = clip48(sadd(alt_e, qmul(k[0], innov, 32)));
    vel_e  = clip48(sadd(vel_e, qmul(k[1], innov, 32)));
    bias_e = clip48(sadd(bias_e, qmul(k[2], innov, 32)));
    // correction from the first row as it was before the update
    for (int j = 0; j < 3; j++) row0[j] = cov[j];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cov[3*i+j] = ssub(cov[3*i+j], qmul(k[i], row0[j], 32));
    r.alt = sat32(alt_e);
    r.vel = sat32(vel_e);
    r.sat = clip;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // ---------------- driver ----------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && !in_done) begin
        // hold the item until it is taken
      end else if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= {7'd0, cmd_q.pop_front()};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------- monitor and prediction ----------------
  always @(posedge clk) begin
    kf_out_t got, want;
    kf_in_t  it;
    if (rst) begin
      in_done <= 1'b0;
    end else begin
      in_done <= s_tvalid && s_tready;
      if (cfg_wr_en && cfg_index < 3'd6) begin
        if (cfg_index >= CFG_INIT_ALT) reg_copy[cfg_index] = {16'd0, cfg_data[31:0]};
        else reg_copy[cfg_index] = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        it = s_tdata[80:0];
        est_q.push_back(kf_update(it));
        if (it.cmd == CMD_RESTART) n_restart++;
        else n_meas++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[64:0];
        if (est_q.size() == 0) begin
          report("unexpected result", got.alt, 32'd0);
        end else begin
          want = est_q.pop_front();
          n_checked++;
          if (want.sat) n_sat++;
          if (got.alt !== want.alt) report("altitude_out", got.alt, want.alt);
          if (got.vel !== want.vel) report("velocity_out", got.vel, want.vel);
          if (got.sat !== want.sat) report("saturated", {31'd0, got.sat}, {31'd0, want.sat});
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      wd <= 0;
    end else if (wd >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      wd <= wd + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_regs(logic [47:0] mv, logic [47:0] av, logic [47:0] bv,
                            logic [31:0] ia, logic [31:0] iv, logic [31:0] ib);
    logic [47:0] vals[7];
    logic [2:0]  idx[7];
    vals = '{mv, av, bv, {16'd0, ia}, {16'd0, iv}, {16'd0, ib}, 48'hFFFF_FFFF_FFFF};
    idx  = '{CFG_MEAS_VAR, CFG_ACCEL_VAR, CFG_BIAS_VAR, CFG_INIT_ALT, CFG_INIT_VEL,
             CFG_INIT_BIAS, CFG_NONE};
    for (int i = 0; i < 7; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || s_tvalid || est_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic kf_in_t mk_item(logic c, logic [31:0] al, logic [31:0] ac,
                                     logic [15:0] d);
    kf_in_t it;
    it.cmd = c;
    it.alt = al;
    it.acc = ac;
    it.dt  = d;
    return it;
  endfunction

  // plausible flight track with occasional noise and restarts
  task automatic queue_flight(int n);
    longint track;
    int     roll;
    track = 0;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        cmd_q.push_back(mk_item(CMD_RESTART, $urandom, $urandom, 16'($urandom)));
        track = 0;
      end else if (roll < 15) begin
        cmd_q.push_back(mk_item(CMD_MEAS, $urandom, $urandom, 16'($urandom)));
      end else begin
        track = track + $signed($urandom_range(40000)) - 20000;
        cmd_q.push_back(mk_item(CMD_MEAS, track[31:0] + $urandom_range(3000) - 1500,
                                $urandom_range(1310720) - 655360,
                                16'($urandom_range(400, 1400))));
      end
    end
  endtask

  initial begin
    s_tdata = '0;
    s_tvalid = 1'b0;
    m_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_MEAS_VAR;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    n_meas = 0;
    n_restart = 0;
    n_checked = 0;
    n_sat = 0;
    reg_copy = '{48'h1_0000_0000, 48'h1_0000_0000, 48'd0, 48'd0, 48'd0, 48'd0};
    reload_filter();
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // let the start-up clearing pass finish
    repeat (200) @(posedge clk);

    // phase 1: no idling, directed corner items then a track
    write_regs(48'h1_0000_0000, 48'h1_0000_0000, 48'h0_0100_0000,
               32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    cmd_q.push_back(mk_item(CMD_MEAS, 32'd0, 32'd0, 16'd0));
    cmd_q.push_back(mk_item(CMD_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h0001_0000, 32'h0009_CE80, 16'd655));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h7FFF_FFFF, 32'd0, 16'hFFFF));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h8000_0000, 32'd0, 16'hFFFF));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'd0, 32'h7FFF_FFFF, 16'hFFFF));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'd0, 32'h8000_0000, 16'hFFFF));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h8000_0000, 32'h8000_0000, 16'd1));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0));
    cmd_q.push_back(mk_item(CMD_RESTART, 32'd0, 32'd0, 16'd0));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h0000_8000, 32'hFFF6_3180, 16'd1));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h0002_0000, 32'h0000_0000, 16'h8000));
    queue_flight(140);
    drain();

    // phase 2: sender mostly idle, largest variances and initial values
    send_idle_pct = 87;
    write_regs(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    cmd_q.push_back(mk_item(CMD_RESTART, 32'd0, 32'd0, 16'd0));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
    queue_flight(140);
    drain();

    // phase 3: receiver mostly stalling, zero variances, lowest initial values
    send_idle_pct = 0;
    recv_stall_pct = 87;
    write_regs(48'd0, 48'd0, 48'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    cmd_q.push_back(mk_item(CMD_RESTART, 32'd0, 32'd0, 16'd0));
    cmd_q.push_back(mk_item(CMD_MEAS, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
    queue_flight(140);
    drain();

    // phase 4: both sides idle now and then, random settings
    send_idle_pct = 15;
    recv_stall_pct = 15;
    write_regs({16'($urandom_range(65535)), 32'h0}, {16'd0, $urandom},
               {$urandom, 16'd0} >> 16, $urandom, $urandom, $urandom);
    cmd_q.push_back(mk_item(CMD_RESTART, 32'd0, 32'd0, 16'd0));
    queue_flight(140);
    drain();
    repeat (700) @(posedge clk);

    $display("Checked %0d results: %0d measurements, %0d restarts, %0d saturated steps,",
             n_checked, n_meas, n_restart, n_sat);
    $display("over four handshake pressure phases and four register settings.");
    if (errors == 0 && est_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
